FILE: rtl/core/m6800_pkg.sv
// Package for the 6800 instruction stream decoder: opcode table, modes, queue word.
// No dependencies.
package m6800_pkg;

  typedef enum logic [2:0] {
    MODE_INH = 3'd0,
    MODE_DIR = 3'd1,
    MODE_IND = 3'd2,
    MODE_REL = 3'd3,
    MODE_EXT = 3'd4,
    MODE_IMM = 3'd5
  } mode_t;

  localparam logic [7:0] OP_RTS     = 8'h39;
  localparam logic [7:0] OP_JMP_IND = 8'h6e;
  localparam logic [7:0] OP_JMP_EXT = 8'h7e;
  localparam logic [2:0] CFG_START  = 3'd0;

  typedef struct packed {
    logic       known;
    logic [1:0] nbytes;
    mode_t      mode;
    logic [3:0] cycles;
  } op_info_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  opcode;
    logic [15:0] operand;
  } instr_t;

  function automatic op_info_t op_lookup(input logic [7:0] b);
    op_info_t r;
    r = '{known: 1'b0, nbytes: 2'd0, mode: MODE_INH, cycles: 4'd0};
    case (b)
      8'd1, 8'd6, 8'd7, 8'd10, 8'd11, 8'd12, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17,
      8'd22, 8'd23, 8'd25, 8'd27, 8'd64, 8'd67, 8'd68, 8'd70, 8'd71, 8'd72, 8'd73,
      8'd74, 8'd76, 8'd77, 8'd79, 8'd80, 8'd83, 8'd84, 8'd86, 8'd87, 8'd88, 8'd89,
      8'd90, 8'd92, 8'd93, 8'd95:
        r = '{1'b1, 2'd0, MODE_INH, 4'd2};
      8'd8, 8'd9, 8'd48, 8'd49, 8'd52, 8'd53, 8'd54, 8'd55:
        r = '{1'b1, 2'd0, MODE_INH, 4'd3};
      8'd50, 8'd51: r = '{1'b1, 2'd0, MODE_INH, 4'd4};
      8'd57: r = '{1'b1, 2'd0, MODE_INH, 4'd5};
      8'd59: r = '{1'b1, 2'd0, MODE_INH, 4'd12};
      8'd62: r = '{1'b1, 2'd0, MODE_INH, 4'd14};
      8'd32, 8'd34, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43,
      8'd44, 8'd45, 8'd46, 8'd47:
        r = '{1'b1, 2'd1, MODE_REL, 4'd3};
      8'd141: r = '{1'b1, 2'd1, MODE_REL, 4'd6};
      8'd63: r = '{1'b1, 2'd1, MODE_DIR, 4'd2};
      8'd96, 8'd99, 8'd100, 8'd102, 8'd103, 8'd104, 8'd105, 8'd106, 8'd108, 8'd109,
      8'd111, 8'd172, 8'd173:
        r = '{1'b1, 2'd1, MODE_IND, 4'd6};
      8'd110: r = '{1'b1, 2'd1, MODE_IND, 4'd3};
      8'd112, 8'd115, 8'd116, 8'd118, 8'd119, 8'd120, 8'd121, 8'd122, 8'd124, 8'd125,
      8'd127, 8'd188, 8'd189:
        r = '{1'b1, 2'd2, MODE_EXT, 4'd6};
      8'd126: r = '{1'b1, 2'd2, MODE_EXT, 4'd3};
      8'd128, 8'd129, 8'd130, 8'd132, 8'd133, 8'd134, 8'd136, 8'd137, 8'd138, 8'd139,
      8'd192, 8'd193, 8'd194, 8'd196, 8'd197, 8'd198, 8'd200, 8'd201, 8'd202, 8'd203:
        r = '{1'b1, 2'd1, MODE_IMM, 4'd2};
      8'd140: r = '{1'b1, 2'd2, MODE_IMM, 4'd4};
      8'd142, 8'd206: r = '{1'b1, 2'd2, MODE_IMM, 4'd3};
      8'd144, 8'd145, 8'd146, 8'd148, 8'd149, 8'd150, 8'd151, 8'd152, 8'd153, 8'd154,
      8'd155, 8'd208, 8'd209, 8'd210, 8'd212, 8'd213, 8'd214, 8'd215, 8'd216, 8'd217,
      8'd218, 8'd219:
        r = '{1'b1, 2'd1, MODE_DIR, 4'd3};
      8'd156: r = '{1'b1, 2'd1, MODE_DIR, 4'd5};
      8'd158, 8'd159, 8'd222, 8'd223: r = '{1'b1, 2'd1, MODE_DIR, 4'd4};
      8'd160, 8'd161, 8'd162, 8'd164, 8'd165, 8'd166, 8'd167, 8'd168, 8'd169, 8'd170,
      8'd171, 8'd224, 8'd225, 8'd226, 8'd228, 8'd229, 8'd230, 8'd231, 8'd232, 8'd233,
      8'd234, 8'd235:
        r = '{1'b1, 2'd1, MODE_IND, 4'd4};
      8'd174, 8'd175, 8'd238, 8'd239: r = '{1'b1, 2'd1, MODE_IND, 4'd5};
      8'd176, 8'd177, 8'd178, 8'd180, 8'd181, 8'd182, 8'd183, 8'd184, 8'd185, 8'd186,
      8'd187, 8'd240, 8'd241, 8'd242, 8'd244, 8'd245, 8'd246, 8'd247, 8'd248, 8'd249,
      8'd250, 8'd251, 8'd255:
        r = '{1'b1, 2'd2, MODE_EXT, 4'd4};
      8'd190, 8'd191, 8'd254: r = '{1'b1, 2'd2, MODE_EXT, 4'd5};
      default: r = '{known: 1'b0, nbytes: 2'd0, mode: MODE_INH, cycles: 4'd0};
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/core/m6800_instruction_stream_decoder_top.sv
// Top level of the 6800 instruction stream decoder: APB register, front, queue, back.
// Depends on m6800_pkg, m6800_front, m6800_queue, m6800_back.
// Takes one program byte per cycle while the queue has room; an instruction's word enters
// the queue with its last byte, and the output register loads it from the queue when the
// output is free. Input stalls whenever the two-word queue is full, whatever the output
// register holds.
module m6800_instruction_stream_decoder_top import m6800_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  code_byte,
  input  logic        start_of_stream,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] instr_address,
  output logic [7:0]  opcode_byte,
  output logic        known,
  output logic [2:0]  mode,
  output logic [15:0] operand_value,
  output logic [15:0] target_value,
  output logic [1:0]  length,
  output logic [3:0]  cycle_count,
  output logic        ends_block
);

  logic [15:0] start_address;
  logic        f_valid, f_ready, b_valid, b_ready;
  instr_t      f_word, b_word;

  assign pready = 1'b1;
  assign prdata = (paddr == {CFG_START[0], 2'b00}) ? {16'd0, start_address} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) start_address <= 16'd0;
    else if (psel && penable && pwrite && paddr == {CFG_START[0], 2'b00})
      start_address <= pwdata[15:0];
  end

  m6800_front u_front (
    .clk, .rst, .start_address, .code_byte, .start_of_stream,
    .in_valid, .in_ready, .q_valid(f_valid), .q_ready(f_ready), .q_word(f_word)
  );

  m6800_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_ready(f_ready), .wr_word(f_word),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_word(b_word)
  );

  m6800_back u_back (
    .clk, .rst, .q_valid(b_valid), .q_ready(b_ready), .q_word(b_word),
    .valid(out_valid), .ready(out_ready), .instr_address, .opcode_byte, .known, .mode,
    .operand_value, .target_value, .length, .cycle_count, .ends_block
  );

endmodule

FILE: rtl/core/m6800_front.sv
// Front end: groups program bytes into instructions and tracks addresses.
// Depends on m6800_pkg.
module m6800_front import m6800_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [15:0] start_address,
  input  logic [7:0]  code_byte,
  input  logic        start_of_stream,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        q_valid,
  input  logic        q_ready,
  output instr_t      q_word
);

  logic [15:0] next_address;
  logic [1:0]  bytes_pending;
  logic [7:0]  held_opcode;
  logic [7:0]  high_operand_byte;

  logic [15:0] addr_eff;
  logic [1:0]  pend_eff;
  op_info_t    held_info;
  op_info_t    new_info;
  logic        emit;
  logic        take;

  assign in_ready = q_ready;
  assign take     = in_valid && q_ready;
  assign addr_eff = start_of_stream ? start_address : next_address;
  assign pend_eff = start_of_stream ? 2'd0 : bytes_pending;
  assign held_info = op_lookup(held_opcode);
  assign new_info  = op_lookup(code_byte);

  always_comb begin
    emit   = 1'b0;
    q_word = '{addr: addr_eff, opcode: code_byte, operand: 16'd0};
    case (pend_eff)
      2'd2: emit = 1'b0;
      2'd1: begin
        emit   = 1'b1;
        q_word.opcode = held_opcode;
        q_word.operand = (held_info.known && held_info.nbytes == 2'd2) ?
                         {high_operand_byte, code_byte} : {8'd0, code_byte};
      end
      default: emit = !(new_info.known && new_info.nbytes != 2'd0);
    endcase
  end

  assign q_valid = in_valid && emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      next_address      <= 16'd0;
      bytes_pending     <= 2'd0;
      held_opcode       <= 8'd0;
      high_operand_byte <= 8'd0;
    end else if (take) begin
      next_address <= addr_eff;
      case (pend_eff)
        2'd2: begin
          high_operand_byte <= code_byte;
          bytes_pending     <= 2'd1;
        end
        2'd1: begin
          bytes_pending <= 2'd0;
          next_address  <= addr_eff + (held_info.known ?
                           {14'd0, held_info.nbytes} + 16'd1 : 16'd1);
        end
        default: begin
          if (new_info.known && new_info.nbytes != 2'd0) begin
            held_opcode       <= code_byte;
            high_operand_byte <= 8'd0;
            bytes_pending     <= new_info.nbytes;
          end else begin
            bytes_pending <= 2'd0;
            next_address  <= addr_eff + 16'd1;
          end
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/m6800_queue.sv
// Two-entry word queue between front and back ends.
// Depends on m6800_pkg.
module m6800_queue import m6800_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   wr_valid,
  output logic   wr_ready,
  input  instr_t wr_word,
  output logic   rd_valid,
  input  logic   rd_ready,
  output instr_t rd_word
);

  instr_t     slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign wr_ready = count != 2'd2;
  assign rd_valid = count != 2'd0;
  assign rd_word  = slot[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) slot[wptr] <= wr_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

FILE: rtl/core/m6800_back.sv
// Back end: expands a queued instruction word into the result fields, registered.
// Depends on m6800_pkg.
module m6800_back import m6800_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  instr_t      q_word,
  output logic        valid,
  input  logic        ready,
  output logic [15:0] instr_address,
  output logic [7:0]  opcode_byte,
  output logic        known,
  output logic [2:0]  mode,
  output logic [15:0] operand_value,
  output logic [15:0] target_value,
  output logic [1:0]  length,
  output logic [3:0]  cycle_count,
  output logic        ends_block
);

  op_info_t info;
  logic     load;

  assign info    = op_lookup(q_word.opcode);
  assign q_ready = !valid || ready;
  assign load    = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else if (q_ready) valid <= q_valid;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      instr_address <= q_word.addr;
      opcode_byte   <= q_word.opcode;
      known         <= info.known;
      mode          <= info.mode;
      operand_value <= q_word.operand;
      target_value  <= (info.known && info.mode == MODE_REL) ?
                       {{8{q_word.operand[7]}}, q_word.operand[7:0]} + q_word.addr + 16'd2
                       : q_word.operand;
      length        <= info.known ? info.nbytes + 2'd1 : 2'd1;
      cycle_count   <= info.cycles;
      ends_block    <= info.known && (q_word.opcode == OP_RTS ||
                       q_word.opcode == OP_JMP_IND || q_word.opcode == OP_JMP_EXT);
    end
  end

endmodule

FILE: rtl/core/m6800_checker.sv
// Port-level checks for the 6800 instruction stream decoder, bound to the top level.
// Depends on m6800_pkg and m6800_instruction_stream_decoder_top.
module m6800_checker import m6800_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        known,
  input logic [2:0]  mode,
  input logic [15:0] operand_value,
  input logic [15:0] target_value,
  input logic [1:0]  length,
  input logic [3:0]  cycle_count,
  input logic        ends_block
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(target_value))
    else $error("result dropped while stalled");

  a_unknown: assert property (@(posedge clk) disable iff (rst)
    out_valid && !known |-> length == 2'd1 && cycle_count == 4'd0 && !ends_block
      && operand_value == 16'd0)
    else $error("unknown opcode result malformed");

  a_target: assert property (@(posedge clk) disable iff (rst)
    out_valid && mode != MODE_REL |-> target_value == operand_value)
    else $error("target differs outside relative mode");

  a_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && known && mode == MODE_INH |-> length == 2'd1 && operand_value == 16'd0)
    else $error("inherent instruction with operand");

endmodule

bind m6800_instruction_stream_decoder_top m6800_checker u_checker (.*);

FILE: tb/sv/tb.sv
// Testbench for the 6800 instruction stream decoder: random and directed byte streams,
// a built-in decoder model and a scoreboard on the result channel.
// Depends on m6800_pkg and m6800_instruction_stream_decoder_top.
module tb import m6800_pkg::*; ;

  typedef struct packed {
    logic       known;
    logic [1:0] nbytes;
    mode_t      md;
    logic [3:0] cycles;
  } opinfo_t;

  typedef struct packed {
    logic [15:0] addr;
    logic [7:0]  opc;
    logic        known;
    logic [2:0]  md;
    logic [15:0] operand;
    logic [15:0] target;
    logic [1:0]  len;
    logic [3:0]  cycles;
    logic        ends;
  } decoded_t;

  typedef struct packed {
    logic [7:0] code;
    logic       sos;
  } byte_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  code_byte = '0;
  logic        start_of_stream = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] instr_address;
  logic [7:0]  opcode_byte;
  logic        known;
  logic [2:0]  mode;
  logic [15:0] operand_value;
  logic [15:0] target_value;
  logic [1:0]  length;
  logic [3:0]  cycle_count;
  logic        ends_block;

  m6800_instruction_stream_decoder_top dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  byte_word_t  byte_q[$];
  decoded_t    decoded_q[$];
  int          mismatches = 0;
  logic [15:0] start_reg = '0;
  logic [15:0] next_addr = '0;
  logic [1:0]  pending = '0;
  logic [7:0]  held_op = '0;
  logic [7:0]  high_byte = '0;
  bit          took = 1'b0, got = 1'b0, quiet = 1'b0;
  int          in_gap = 0, out_stall = 0;

  function automatic opinfo_t ent(int nb, mode_t md, int cy);
    return '{1'b1, 2'(nb), md, 4'(cy)};
  endfunction

  function automatic opinfo_t op_info(logic [7:0] b);
    opinfo_t r;
    logic [3:0] l;
    r = '{1'b0, 2'd0, MODE_INH, 4'd0};
    l = b[3:0];
    case (b[7:4])
      4'h0, 4'h1: if (b inside {1, [6:17], 22, 23, 25, 27})
        r = ent(0, MODE_INH, (b == 8 || b == 9) ? 3 : 2);
      4'h2: if (l != 1) r = ent(1, MODE_REL, 3);
      4'h3: begin
        if (b inside {48, 49, [52:55]}) r = ent(0, MODE_INH, 3);
        if (b inside {50, 51}) r = ent(0, MODE_INH, 4);
        if (b == OP_RTS) r = ent(0, MODE_INH, 5);
        if (b == 59) r = ent(0, MODE_INH, 12);
        if (b == 62) r = ent(0, MODE_INH, 14);
        if (b == 63) r = ent(1, MODE_DIR, 2);
      end
      4'h4, 4'h5: if (l inside {0, 3, 4, [6:10], 12, 13, 15}) r = ent(0, MODE_INH, 2);
      4'h6: if (l inside {0, 3, 4, [6:10], [12:15]})
        r = ent(1, MODE_IND, (l == 14) ? 3 : 6);
      4'h7: if (l inside {0, 3, 4, [6:10], [12:15]})
        r = ent(2, MODE_EXT, (l == 14) ? 3 : 6);
      4'h8, 4'hc: begin
        if (l inside {0, 1, 2, 4, 5, 6, 8, 9, 10, 11}) r = ent(1, MODE_IMM, 2);
        if (b == 140) r = ent(2, MODE_IMM, 4);
        if (b == 141) r = ent(1, MODE_REL, 6);
        if (b == 142 || b == 206) r = ent(2, MODE_IMM, 3);
      end
      4'h9, 4'hd: begin
        if (l inside {0, 1, 2, [4:11]}) r = ent(1, MODE_DIR, 3);
        if (b == 156) r = ent(1, MODE_DIR, 5);
        if (l inside {14, 15}) r = ent(1, MODE_DIR, 4);
      end
      4'ha, 4'he: begin
        if (l inside {0, 1, 2, [4:11]}) r = ent(1, MODE_IND, 4);
        if (b inside {172, 173}) r = ent(1, MODE_IND, 6);
        if (l inside {14, 15}) r = ent(1, MODE_IND, 5);
      end
      default: begin
        if (l inside {0, 1, 2, [4:11]}) r = ent(2, MODE_EXT, 4);
        if (b inside {188, 189}) r = ent(2, MODE_EXT, 6);
        if (b inside {190, 191, 254}) r = ent(2, MODE_EXT, 5);
        if (b == 255) r = ent(2, MODE_EXT, 4);
      end
    endcase
    return r;
  endfunction

  function automatic void emit_instr(logic [7:0] opc, logic [15:0] operand);
    opinfo_t  e;
    decoded_t d;
    e = op_info(opc);
    d.addr = next_addr;
    d.opc = opc;
    d.known = e.known;
    d.md = e.md;
    d.operand = operand;
    d.target = (e.known && e.md == MODE_REL) ?
               16'({{8{operand[7]}}, operand[7:0]} + next_addr + 16'd2) : operand;
    d.len = e.known ? e.nbytes + 2'd1 : 2'd1;
    d.cycles = e.cycles;
    d.ends = e.known && (opc == OP_RTS || opc == OP_JMP_IND || opc == OP_JMP_EXT);
    decoded_q.push_back(d);
    next_addr = next_addr + 16'(d.len);
  endfunction

  function automatic void decode_byte(byte_word_t w);
    opinfo_t e;
    if (w.sos) begin
      next_addr = start_reg;
      pending = 2'd0;
    end
    if (pending == 2) begin
      high_byte = w.code;
      pending = 2'd1;
    end else if (pending == 1) begin
      pending = 2'd0;
      emit_instr(held_op, (op_info(held_op).nbytes == 2) ? {high_byte, w.code}
                                                          : {8'd0, w.code});
    end else begin
      e = op_info(w.code);
      if (e.known && e.nbytes != 0) begin
        held_op = w.code;
        high_byte = 8'd0;
        pending = e.nbytes;
      end else begin
        emit_instr(w.code, 16'd0);
      end
    end
  endfunction

  always @(posedge clk) begin
    decoded_t act;
    took <= in_valid && in_ready;
    got <= out_valid && out_ready;
    if (in_valid && in_ready) decode_byte('{code_byte, start_of_stream});
    if (out_valid && out_ready) begin
      act = '{instr_address, opcode_byte, known, mode, operand_value, target_value,
              length, cycle_count, ends_block};
      if (decoded_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", act);
      end else begin
        if (act !== decoded_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", decoded_q[0], act);
        end
        void'(decoded_q.pop_front());
      end
    end
  end

  // hold the word until taken, then idle for the drawn gap
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !took) begin
      end else if (in_gap > 0) begin
        in_valid <= 1'b0;
        in_gap--;
      end else if (byte_q.size() != 0) begin
        {code_byte, start_of_stream} <= byte_q.pop_front();
        in_valid <= 1'b1;
        if ($urandom_range(0, 40) == 0) quiet = !quiet;
        in_gap = quiet ? 0 : $urandom_range(0, 4);
      end else begin
        in_valid <= 1'b0;
      end
      if (got) out_stall = quiet ? 0 : $urandom_range(0, 4);
      if (out_stall > 0) begin
        out_ready <= 1'b0;
        out_stall--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_start(logic [15:0] v);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(CFG_START * 4);
    pwdata <= {16'd0, v};
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    start_reg = v;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (byte_q.size() != 0 || in_valid || decoded_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic push(logic [7:0] c, logic s);
    byte_q.push_back('{c, s});
  endtask

  initial begin
    logic [7:0] opc;
    int         n;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    write_start(16'hfffe);
    push(8'h20, 1); push(8'h7f, 0);
    push(8'h20, 0); push(8'h80, 0);
    push(OP_JMP_EXT, 0); push(8'hff, 0); push(8'hff, 0);
    push(OP_JMP_IND, 0); push(8'h00, 0);
    push(OP_RTS, 0); push(8'h00, 0); push(8'h3f, 0); push(8'h55, 0);
    push(8'hff, 0); push(8'h12, 1);
    push(8'hff, 0); push(8'h12, 0); push(8'h34, 0);
    push(8'h8d, 0); push(8'hfe, 0);
    push(8'h87, 0); push(8'h3e, 0); push(8'h01, 1);
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      write_start(ph == 0 ? 16'h0000 : ph == 1 ? 16'hffff : 16'($urandom));
      n = 0;
      while (n < 300) begin
        opc = 8'($urandom);
        push(opc, $urandom_range(0, 15) == 0);
        n++;
        if (op_info(opc).known)
          for (int k = 0; k < op_info(opc).nbytes; k++) begin
            push(8'($urandom), $urandom_range(0, 40) == 0);
            n++;
          end
      end
      drain();
    end
    if (mismatches == 0 && decoded_q.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

FILE: files.f
rtl/core/m6800_pkg.sv
rtl/core/m6800_front.sv
rtl/core/m6800_queue.sv
rtl/core/m6800_back.sv
rtl/core/m6800_instruction_stream_decoder_top.sv
rtl/core/m6800_checker.sv
tb/sv/tb.sv
